// ===== rtl/efv_pkg.sv =====
// ----------------------------------------------------------------------------
// efv_pkg
// Shared constants, register codes and records of the event frame validator.
// ----------------------------------------------------------------------------
package efv_pkg;

	localparam int WordBits      = 32;
	localparam int MaxEventWords = 65535;

	localparam logic [31:0] WordMask =
		(WordBits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << WordBits) - 32'd1);

	typedef enum logic [1:0] {
		CFG_HEADER    = 2'd0,
		CFG_FOOTER    = 2'd1,
		CFG_DELIMITER = 2'd2,
		CFG_COUNTER   = 2'd3
	} efv_cfg_idx_t;

	typedef struct packed {
		logic [31:0] header_word;
		logic [31:0] footer_word;
		logic [31:0] delimiter_word;
		logic [7:0]  counter_words;
	} efv_cfg_t;

	typedef struct packed {
		logic [15:0] word_count;
		logic        header_ok;
		logic [1:0]  delimiter_count;
		logic [15:0] first_delimiter_pos;
		logic        overflowed;
		logic        footer_match;
	} efv_tally_t;

	typedef struct packed {
		logic        good_event;
		logic        multiple_delimiters;
		logic        unexpected_error;
		logic        overlong;
		logic [15:0] first_section_offset;
		logic [15:0] second_section_offset;
	} efv_verdict_t;

	function automatic logic [31:0] efv_mask(input logic [31:0] w);
		return w & WordMask;
	endfunction

endpackage

// ===== rtl/efv_word_if.sv =====
// ----------------------------------------------------------------------------
// efv_word_if
// Input channel: one event word per transaction with its last-word mark.
// ----------------------------------------------------------------------------
interface efv_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] word;
	logic        last;

	modport source (output valid, output word, output last, input ready);
	modport sink (input valid, input word, input last, output ready);
endinterface

// ===== rtl/efv_verdict_if.sv =====
// ----------------------------------------------------------------------------
// efv_verdict_if
// Output channel: one framing verdict per transaction.
// ----------------------------------------------------------------------------
interface efv_verdict_if;
	logic        valid;
	logic        ready;
	logic        good_event;
	logic        multiple_delimiters;
	logic        unexpected_error;
	logic        overlong;
	logic [15:0] first_section_offset;
	logic [15:0] second_section_offset;

	modport source (
		output valid, output good_event, output multiple_delimiters,
		output unexpected_error, output overlong,
		output first_section_offset, output second_section_offset,
		input ready
	);
	modport sink (
		input valid, input good_event, input multiple_delimiters,
		input unexpected_error, input overlong,
		input first_section_offset, input second_section_offset,
		output ready
	);
endinterface

// ===== rtl/event_frame_validator.sv =====
// ----------------------------------------------------------------------------
// event_frame_validator
// Framing check of readout events, one verdict per event.
// The closing word goes through the input register, then the result register.
// Throughput: one word per cycle; the input register and the per-event tally
// update are both registered; a closing word waits only on an untaken verdict.
// Reset clears the configuration registers to zero and the event tally.
// ----------------------------------------------------------------------------
module event_frame_validator
	import efv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	efv_word_if.sink    words,
	efv_verdict_if.source verdicts
);

	efv_cfg_t   cfg_q;
	efv_tally_t tally;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic        last_s1;
	logic        slot_free;
	logic        advance;
	logic        take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (efv_cfg_idx_t'(cfg_index))
				CFG_HEADER:    cfg_q.header_word    <= cfg_data;
				CFG_FOOTER:    cfg_q.footer_word    <= cfg_data;
				CFG_DELIMITER: cfg_q.delimiter_word <= cfg_data;
				CFG_COUNTER:   cfg_q.counter_words  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign advance     = !last_s1 || slot_free;
	assign take        = valid_s1 && advance;
	assign words.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (words.valid && words.ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (words.valid && words.ready) begin
			word_s1 <= words.word;
			last_s1 <= words.last;
		end
	end

	efv_frame_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.word   (word_s1),
		.last   (last_s1),
		.cfg    (cfg_q),
		.tally  (tally)
	);

	efv_verdict u_verdict (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (take && last_s1),
		.tally         (tally),
		.counter_words (cfg_q.counter_words),
		.slot_free     (slot_free),
		.verdicts      (verdicts)
	);

endmodule

// ===== rtl/efv_frame_state.sv =====
// ----------------------------------------------------------------------------
// efv_frame_state
// Per-event tally: word count, header match, delimiter count and position.
// ----------------------------------------------------------------------------
module efv_frame_state
	import efv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [31:0] word,
	input  logic        last,
	input  efv_cfg_t    cfg,
	output efv_tally_t  tally
);

	logic [15:0] word_count_q;
	logic        header_ok_q;
	logic [1:0]  delimiter_count_q;
	logic [15:0] first_delimiter_pos_q;
	logic        overflowed_q;

	logic [31:0] w;
	logic        is_delim;

	assign w        = efv_mask(word);
	assign is_delim = (w == efv_mask(cfg.delimiter_word));

	always_comb begin
		tally.word_count          = word_count_q;
		tally.header_ok           = header_ok_q;
		tally.delimiter_count     = delimiter_count_q;
		tally.first_delimiter_pos = first_delimiter_pos_q;
		tally.overflowed          = overflowed_q;
		tally.footer_match        = (w == efv_mask(cfg.footer_word));
		if (word_count_q >= 16'(MaxEventWords)) begin
			tally.overflowed = 1'b1;
		end else begin
			if (word_count_q == 16'd0) begin
				tally.header_ok = (w == efv_mask(cfg.header_word));
			end
			if (is_delim) begin
				if (delimiter_count_q == 2'd0) begin
					tally.first_delimiter_pos = word_count_q;
				end
				if (delimiter_count_q < 2'd2) begin
					tally.delimiter_count = delimiter_count_q + 2'd1;
				end
			end
			tally.word_count = word_count_q + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q          <= '0;
			header_ok_q           <= 1'b0;
			delimiter_count_q     <= '0;
			first_delimiter_pos_q <= '0;
			overflowed_q          <= 1'b0;
		end else if (take) begin
			if (last) begin
				word_count_q          <= '0;
				header_ok_q           <= 1'b0;
				delimiter_count_q     <= '0;
				first_delimiter_pos_q <= '0;
				overflowed_q          <= 1'b0;
			end else begin
				word_count_q          <= tally.word_count;
				header_ok_q           <= tally.header_ok;
				delimiter_count_q     <= tally.delimiter_count;
				first_delimiter_pos_q <= tally.first_delimiter_pos;
				overflowed_q          <= tally.overflowed;
			end
		end
	end

	a_clear_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		(take && last) |=> (word_count_q == 16'd0 && delimiter_count_q == 2'd0))
		else $error("event state not cleared after closing word");

	a_delim_sat: assert property (@(posedge clk) disable iff (!arst_n)
		delimiter_count_q != 2'd3)
		else $error("delimiter count passed saturation");

endmodule

// ===== rtl/efv_verdict.sv =====
// ----------------------------------------------------------------------------
// efv_verdict
// Verdict logic on the closing word and the registered result channel.
// ----------------------------------------------------------------------------
module efv_verdict
	import efv_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  efv_tally_t         tally,
	input  logic [7:0]         counter_words,
	output logic               slot_free,
	efv_verdict_if.source      verdicts
);

	efv_verdict_t res;
	efv_verdict_t res_q;
	logic         valid_q;

	logic [16:0] n;
	logic [16:0] off_a;
	logic [16:0] off_b;
	logic [16:0] short_len;

	assign n         = {1'b0, tally.word_count};
	assign off_a     = 17'(counter_words) + 17'd1;
	assign off_b     = {1'b0, tally.first_delimiter_pos} + 17'd1;
	assign short_len = 17'(counter_words) + 17'd2;

	always_comb begin
		res = '0;
		if (tally.overflowed) begin
			res.overlong = 1'b1;
		end else if (n < 17'd2 || !tally.header_ok || !tally.footer_match) begin
			res.good_event = 1'b0;
		end else if (n == short_len) begin
			res.good_event = 1'b1;
		end else if (tally.delimiter_count == 2'd0) begin
			res.good_event = 1'b0;
		end else begin
			res.multiple_delimiters   = (tally.delimiter_count > 2'd1);
			res.first_section_offset  = off_a[15:0];
			res.second_section_offset = off_b[15:0];
			if (off_a >= n || off_b >= n) begin
				res.unexpected_error = 1'b1;
			end else begin
				res.good_event = 1'b1;
			end
		end
	end

	assign slot_free = !valid_q || verdicts.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (verdicts.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign verdicts.valid                 = valid_q;
	assign verdicts.good_event            = res_q.good_event;
	assign verdicts.multiple_delimiters   = res_q.multiple_delimiters;
	assign verdicts.unexpected_error      = res_q.unexpected_error;
	assign verdicts.overlong              = res_q.overlong;
	assign verdicts.first_section_offset  = res_q.first_section_offset;
	assign verdicts.second_section_offset = res_q.second_section_offset;

	a_load_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> slot_free)
		else $error("verdict loaded over an untaken result");

	a_good_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.good_event) |-> (!res_q.unexpected_error && !res_q.overlong))
		else $error("good verdict carries an error flag");

endmodule

// ===== dv/tb_event_frame_validator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_event_frame_validator
// Drives readout events word by word into the frame validator under several
// register settings, tracks the event framing rules in a local tally and
// checks every verdict field against that tally, or against the planned
// verdict for typed plan rows, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_event_frame_validator;
	import efv_pkg::*;

	localparam int ROWS   = 12;
	localparam int SETTLE = 6;

	typedef struct packed {
		logic [1:0]   setting;
		logic [15:0]  len;
		logic         hdr;
		logic         ftr;
		logic [15:0]  d1;
		logic [15:0]  d2;
		logic         typed;
		efv_verdict_t verdict;
	} frame_row_t;

	localparam efv_cfg_t PRESETS [3] = '{
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'd0},
		'{32'hA5A5_0001, 32'h5A5A_FFFE, 32'hDDDD_0000, 8'd1},
		'{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0}
	};

	// verdict flags: good, multiple delimiters, unexpected, overlong
	localparam frame_row_t PLAN [ROWS] = '{
		'{2'd0, 16'd2, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1, {4'b1000, 16'd0, 16'd0}},
		'{2'd0, 16'd1, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1, 36'd0},
		'{2'd1, 16'd1, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1, 36'd0},
		'{2'd1, 16'd3, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1, {4'b1000, 16'd0, 16'd0}},
		'{2'd1, 16'd2, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1, 36'd0},
		'{2'd1, 16'd2, 1'b0, 1'b1, 16'd0, 16'd0, 1'b1, 36'd0},
		'{2'd1, 16'd2, 1'b1, 1'b0, 16'd0, 16'd0, 1'b1, 36'd0},
		'{2'd1, 16'd4, 1'b1, 1'b1, 16'd1, 16'd0, 1'b1, {4'b1000, 16'd2, 16'd2}},
		'{2'd1, 16'd4, 1'b1, 1'b1, 16'd1, 16'd2, 1'b1, {4'b1100, 16'd2, 16'd2}},
		'{2'd1, 16'd4, 1'b1, 1'b1, 16'd2, 16'd0, 1'b0, 36'd0},
		'{2'd2, 16'd3, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1, {4'b0010, 16'd1, 16'd3}},
		'{2'd2, 16'd2, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1, {4'b1000, 16'd0, 16'd0}}
	};

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	efv_cfg_idx_t   cfg_index;
	logic [31:0]    cfg_data;

	efv_word_if     words ();
	efv_verdict_if  verdicts ();

	efv_cfg_t       model_regs = '0;
	efv_cfg_t       drive_regs = '0;
	int unsigned    tally_words = 0;
	bit             tally_hdr = 1'b0;
	int unsigned    tally_delims = 0;
	int unsigned    tally_first_delim = 0;
	bit             tally_over = 1'b0;
	efv_verdict_t   verdicts_due [$];
	int             closed_events = 0;
	int             faults = 0;
	bit             feed_calm = 1'b0;
	bit             sink_calm = 1'b0;

	event_frame_validator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.words     (words),
		.verdicts  (verdicts)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report(input string msg);
		faults++;
		if (faults <= 40)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	function automatic bit judge_word(input logic [31:0] raw, input logic lst,
			output efv_verdict_t v);
		logic [31:0] w;
		int unsigned a;
		int unsigned b;
		w = raw & WordMask;
		v = '0;
		if (tally_words >= MaxEventWords) begin
			tally_over = 1'b1;
		end else begin
			if (tally_words == 0)
				tally_hdr = (w == (model_regs.header_word & WordMask));
			if (w == (model_regs.delimiter_word & WordMask)) begin
				if (tally_delims == 0)
					tally_first_delim = tally_words;
				if (tally_delims < 2)
					tally_delims++;
			end
			tally_words++;
		end
		if (!lst)
			return 1'b0;
		if (tally_over) begin
			v.overlong = 1'b1;
		end else if (tally_words < 2 || !tally_hdr
				|| w != (model_regs.footer_word & WordMask)) begin
		end else if (tally_words == model_regs.counter_words + 32'd2) begin
			v.good_event = 1'b1;
		end else if (tally_delims != 0) begin
			a = 1 + model_regs.counter_words;
			b = tally_first_delim + 1;
			v.multiple_delimiters = (tally_delims > 1);
			v.first_section_offset = a[15:0];
			v.second_section_offset = b[15:0];
			if (a >= tally_words || b >= tally_words)
				v.unexpected_error = 1'b1;
			else
				v.good_event = 1'b1;
		end
		tally_words = 0;
		tally_hdr = 1'b0;
		tally_delims = 0;
		tally_first_delim = 0;
		tally_over = 1'b0;
		return 1'b1;
	endfunction

	always @(posedge clk) begin : watch_in
		efv_verdict_t v;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_HEADER:    model_regs.header_word = cfg_data;
					CFG_FOOTER:    model_regs.footer_word = cfg_data;
					CFG_DELIMITER: model_regs.delimiter_word = cfg_data;
					CFG_COUNTER:   model_regs.counter_words = cfg_data[7:0];
					default: ;
				endcase
			end
			if (words.valid && words.ready && judge_word(words.word, words.last, v)) begin
				if (closed_events < ROWS && PLAN[closed_events].typed)
					v = PLAN[closed_events].verdict;
				verdicts_due.push_back(v);
				closed_events++;
			end
		end
	end

	always @(posedge clk) begin : watch_out
		efv_verdict_t want;
		if (arst_n && verdicts.valid && verdicts.ready) begin
			if (verdicts_due.size() == 0) begin
				report("verdict transaction with none pending");
			end else begin
				want = verdicts_due.pop_front();
				if (verdicts.good_event !== want.good_event)
					report($sformatf("good_event got %0d want %0d",
						verdicts.good_event, want.good_event));
				if (verdicts.multiple_delimiters !== want.multiple_delimiters)
					report($sformatf("multiple_delimiters got %0d want %0d",
						verdicts.multiple_delimiters, want.multiple_delimiters));
				if (verdicts.unexpected_error !== want.unexpected_error)
					report($sformatf("unexpected_error got %0d want %0d",
						verdicts.unexpected_error, want.unexpected_error));
				if (verdicts.overlong !== want.overlong)
					report($sformatf("overlong got %0d want %0d",
						verdicts.overlong, want.overlong));
				if (verdicts.first_section_offset !== want.first_section_offset)
					report($sformatf("first_section_offset got %0d want %0d",
						verdicts.first_section_offset, want.first_section_offset));
				if (verdicts.second_section_offset !== want.second_section_offset)
					report($sformatf("second_section_offset got %0d want %0d",
						verdicts.second_section_offset, want.second_section_offset));
			end
		end
	end

	initial begin : sink
		int stall;
		verdicts.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if ($urandom_range(0, 9) == 0)
				sink_calm = !sink_calm;
			stall = sink_calm ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				verdicts.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			verdicts.ready <= 1'b1;
			do @(posedge clk); while (!(verdicts.valid && verdicts.ready));
		end
	end

	task automatic push_word(input logic [31:0] w, input bit lst, input bit steady);
		int gap;
		gap = feed_calm ? 0 : $urandom_range(0, 6);
		if (steady && $urandom_range(0, 31) != 0)
			gap = 0;
		if (gap > 0) begin
			words.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		words.valid <= 1'b1;
		words.word <= w;
		words.last <= lst;
		do @(posedge clk); while (!words.ready);
	endtask

	task automatic send_event(input int len, input bit hdr, input bit ftr,
			input int d1, input int d2, input bit steady);
		logic [31:0] w;
		if ($urandom_range(0, 4) == 0)
			feed_calm = !feed_calm;
		for (int p = 0; p < len; p++) begin
			w = $urandom();
			if (w == drive_regs.delimiter_word)
				w ^= 32'd1;
			if (p != 0 && (p == d1 || p == d2))
				w = drive_regs.delimiter_word;
			if (p == 0)
				w = hdr ? drive_regs.header_word
					: drive_regs.header_word ^ (32'd1 << $urandom_range(0, 31));
			if (p == len - 1)
				w = ftr ? drive_regs.footer_word
					: drive_regs.footer_word ^ (32'd1 << $urandom_range(0, 31));
			push_word(w, p == len - 1, steady);
		end
	endtask

	// hold the feed until every pending verdict is back, then let the pipe settle
	task automatic drain();
		words.valid <= 1'b0;
		do @(posedge clk); while (verdicts_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input efv_cfg_idx_t idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic apply_setting(input efv_cfg_t s);
		logic [31:0] spare;
		spare = $urandom();
		drive_regs = s;
		write_reg(CFG_HEADER, s.header_word);
		write_reg(CFG_FOOTER, s.footer_word);
		write_reg(CFG_DELIMITER, s.delimiter_word);
		write_reg(CFG_COUNTER, {spare[31:8], s.counter_words});
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int cur;
		int mark;
		int sent;
		int kind;
		int cw;
		int len;
		int d1;
		int d2;
		bit hdr;
		bit ftr;
		efv_cfg_t s;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_HEADER;
		cfg_data <= '0;
		words.valid <= 1'b0;
		words.word <= '0;
		words.last <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur = 0;
		for (int r = 0; r < ROWS; r++) begin
			if (PLAN[r].setting != cur) begin
				drain();
				cur = PLAN[r].setting;
				apply_setting(PRESETS[cur]);
			end
			send_event(PLAN[r].len, PLAN[r].hdr, PLAN[r].ftr, PLAN[r].d1, PLAN[r].d2, 1'b0);
		end

		sent = 0;
		for (int k = 0; k < 6; k++) begin
			drain();
			s.header_word = $urandom();
			s.footer_word = $urandom();
			s.delimiter_word = $urandom();
			s.counter_words = $urandom_range(0, 3);
			case (k)
				1: begin
					s.header_word = 32'hFFFF_FFFF;
					s.footer_word = 32'h0000_0000;
					s.counter_words = 8'd0;
				end
				2: s.header_word = s.delimiter_word;
				3: s.footer_word = s.delimiter_word;
				4: s.counter_words = 8'd255;
				5: s.counter_words = $urandom_range(0, 6);
				default: ;
			endcase
			apply_setting(s);
			if (k == 4) begin
				send_event(257, 1'b1, 1'b1, 0, 0, 1'b1);
				send_event(20, 1'b1, 1'b1, 5, 0, 1'b0);
			end else begin
				mark = sent;
				while (sent - mark < 65) begin
					kind = $urandom_range(0, 9);
					cw = drive_regs.counter_words;
					hdr = 1'b1;
					ftr = 1'b1;
					d1 = 0;
					d2 = 0;
					if (kind <= 7) begin
						len = ($urandom_range(0, 3) == 0) ? cw + 2 : $urandom_range(2, cw + 8);
						if (len >= 3) begin
							if ($urandom_range(0, 3) != 0)
								d1 = $urandom_range(1, len - 2);
							if ($urandom_range(0, 2) == 0)
								d2 = $urandom_range(1, len - 2);
						end
						hdr = (kind != 6);
						ftr = (kind != 7);
					end else if (kind == 8) begin
						len = $urandom_range(1, 2);
					end else begin
						len = $urandom_range(1, 12);
						hdr = $urandom_range(0, 1);
						ftr = $urandom_range(0, 1);
					end
					send_event(len, hdr, ftr, d1, d2, 1'b0);
					sent += len;
					if ($urandom_range(0, 15) == 0)
						drain();
				end
			end
		end
		drain();

		if (faults == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/efv_pkg.sv
rtl/efv_word_if.sv
rtl/efv_verdict_if.sv
rtl/efv_frame_state.sv
rtl/efv_verdict.sv
rtl/event_frame_validator.sv
dv/tb_event_frame_validator.sv
